@@ rtl/hck_pkg.sv @@
// Shared types and constants of the chained hash key counter.
package hck_pkg;

	localparam int KEY_W    = 32;
	localparam int COUNT_W  = 32;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 11;
	localparam int CMD_W    = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_LOOKUP = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

endpackage

@@ rtl/hck_if.sv @@
// Valid/ready channel interfaces for requests and responses.
interface hck_req_if import hck_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [KEY_W-1:0]   key;
	modport source (output valid, cmd, key, input ready);
	modport sink   (input valid, cmd, key, output ready);
endinterface

interface hck_rsp_if import hck_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [COUNT_W-1:0]  count;
	logic [STATUS_W-1:0] status;
	logic [OCC_W-1:0]    occupancy;
	modport source (output valid, count, status, occupancy, input ready);
	modport sink   (input valid, count, status, occupancy, output ready);
endinterface

@@ rtl/chained_hash_key_counter_unit.sv @@
// Chained hash key counter: top level with bucket, node and free-list memories.
// Usage:
//   req channel carries cmd (insert, remove, lookup; code 3 acts as lookup) and key.
//   rsp channel returns count, status and occupancy, one transaction per request.
// Operation is one request at a time. A request is taken in the idle state,
// even while the previous response still waits in the output register.
// A request reads its bucket head, then walks the chain: for each node a read
// state and a compare state, until the key matches or the chain ends. The
// response is loaded as soon as the output register is free, and the next
// request can be taken in the cycle after that. Each node of the walk needs
// both states because the node memory read is registered.
// A refused insert on a full table skips the chain walk and answers directly.
// After reset a clearing pass over all TABLE_ENTRIES entries empties the
// bucket heads and fills the free list; no request is taken during that pass.
// When the receiver stalls, the response holds and the next request waits
// at its end before it can be delivered.
// TABLE_ENTRIES must be a power of two; the bucket is the key's low bits.
module chained_hash_key_counter_unit import hck_pkg::*; #(
	parameter int TABLE_ENTRIES = 1024,
	parameter int KEY_BITS      = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	hck_req_if.sink     req,
	hck_rsp_if.source   rsp
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int PW = AW + 1;
	localparam logic [PW-1:0] NO_NODE = PW'(TABLE_ENTRIES);
	localparam logic [PW-1:0] LAST_IDX = PW'(TABLE_ENTRIES - 1);
	localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BITS >= KEY_W) ? '1 :
		KEY_W'((64'd1 << KEY_BITS) - 64'd1);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_HEAD, S_WALK, S_NODE, S_DONE
	} state_t;

	state_t              state_q;
	logic [PW-1:0]       clr_q;
	logic [PW-1:0]       stored_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [KEY_W-1:0]    key_q;
	logic [AW-1:0]       bkt_q;
	logic [PW-1:0]       cur_q, head_q, prev_q;
	logic [KEY_W-1:0]    pk_q;
	logic [COUNT_W-1:0]  pc_q;
	logic [COUNT_W-1:0]  res_count_q;
	logic [STATUS_W-1:0] res_status_q;

	// memories
	logic [PW-1:0]      heads_mem [TABLE_ENTRIES];
	logic [KEY_W-1:0]   nk_mem    [TABLE_ENTRIES];
	logic [COUNT_W-1:0] nc_mem    [TABLE_ENTRIES];
	logic [PW-1:0]      nl_mem    [TABLE_ENTRIES];
	logic [AW-1:0]      free_mem  [TABLE_ENTRIES];

	logic [PW-1:0]      heads_rd;
	logic [KEY_W-1:0]   nk_rd;
	logic [COUNT_W-1:0] nc_rd;
	logic [PW-1:0]      nl_rd;
	logic [AW-1:0]      free_rd;

	logic               heads_we, node_we, free_we, node_re, accept;
	logic [AW-1:0]      heads_wa, node_wa, free_wa;
	logic [PW-1:0]      heads_wd, nl_wd;
	logic [KEY_W-1:0]   nk_wd;
	logic [COUNT_W-1:0] nc_wd;
	logic [AW-1:0]      free_wd;
	logic               found, stored_inc, stored_dec, fin;
	logic [COUNT_W-1:0] inc_cnt, dec_cnt, fin_count;
	logic [STATUS_W-1:0] fin_status;
	logic [KEY_W-1:0]   key_in;

	assign key_in    = req.key & KEY_MASK;
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign found     = (state_q == S_NODE) && (nk_rd == key_q);
	assign inc_cnt   = (nc_rd == COUNT_MAX) ? nc_rd : nc_rd + COUNT_W'(1);
	assign dec_cnt   = (nc_rd != '0) ? nc_rd - COUNT_W'(1) : '0;
	assign node_re   = (state_q == S_WALK) && !cur_q[AW];

	always_comb begin
		heads_we = 1'b0; heads_wa = bkt_q; heads_wd = NO_NODE;
		node_we = 1'b0; node_wa = cur_q[AW-1:0];
		nk_wd = key_q; nc_wd = inc_cnt; nl_wd = nl_rd;
		free_we = 1'b0; free_wa = clr_q[AW-1:0]; free_wd = clr_q[AW-1:0];
		stored_inc = 1'b0; stored_dec = 1'b0;
		fin = 1'b0; fin_count = '0; fin_status = ST_OK;
		case (state_q)
			S_CLEAR: begin
				heads_we = 1'b1; heads_wa = clr_q[AW-1:0];
				free_we = 1'b1;
			end
			S_WALK: begin
				if (cur_q[AW]) begin
					fin = 1'b1;
					if (cmd_q == CMD_INSERT) begin
						node_we = 1'b1; node_wa = free_rd;
						nc_wd = COUNT_W'(1); nl_wd = head_q;
						heads_we = 1'b1; heads_wd = {1'b0, free_rd};
						stored_inc = 1'b1; fin_count = COUNT_W'(1);
					end else begin
						fin_status = ST_NOT_FOUND;
					end
				end
			end
			S_NODE: begin
				if (found) begin
					fin = 1'b1;
					case (cmd_q)
						CMD_INSERT: begin
							node_we = 1'b1; fin_count = inc_cnt;
						end
						CMD_REMOVE: begin
							fin_count = dec_cnt;
							if (dec_cnt != '0) begin
								node_we = 1'b1; nc_wd = dec_cnt;
							end else begin
								if (!prev_q[AW]) begin
									node_we = 1'b1; node_wa = prev_q[AW-1:0];
									nk_wd = pk_q; nc_wd = pc_q;
								end else begin
									heads_we = 1'b1; heads_wd = nl_rd;
								end
								free_we = 1'b1;
								free_wa = AW'(stored_q - PW'(1));
								free_wd = cur_q[AW-1:0];
								stored_dec = 1'b1;
							end
						end
						default: fin_count = nc_rd;
					endcase
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (heads_we) heads_mem[heads_wa] <= heads_wd;
		if (accept) heads_rd <= heads_mem[key_in[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (node_we) begin
			nk_mem[node_wa] <= nk_wd;
			nc_mem[node_wa] <= nc_wd;
			nl_mem[node_wa] <= nl_wd;
		end
		if (node_re) begin
			nk_rd <= nk_mem[cur_q[AW-1:0]];
			nc_rd <= nc_mem[cur_q[AW-1:0]];
			nl_rd <= nl_mem[cur_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (free_we) free_mem[free_wa] <= free_wd;
		if (accept) free_rd <= free_mem[stored_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.cmd; key_q <= key_in; bkt_q <= key_in[AW-1:0];
		end
		if (state_q == S_HEAD) begin
			cur_q <= heads_rd; head_q <= heads_rd; prev_q <= NO_NODE;
		end
		if (state_q == S_NODE && !found) begin
			prev_q <= cur_q; pk_q <= nk_rd; pc_q <= nc_rd; cur_q <= nl_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			stored_q <= '0;
			rsp.valid <= 1'b0;
			res_count_q <= '0;
			res_status_q <= ST_OK;
			rsp.count <= '0;
			rsp.status <= ST_OK;
			rsp.occupancy <= '0;
		end else begin
			if (rsp.valid && rsp.ready && state_q != S_DONE) rsp.valid <= 1'b0;
			if (stored_inc) stored_q <= stored_q + PW'(1);
			if (stored_dec) stored_q <= stored_q - PW'(1);
			if (fin) begin
				res_count_q <= fin_count; res_status_q <= fin_status;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + PW'(1);
					if (clr_q == LAST_IDX) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						if (req.cmd == CMD_INSERT && stored_q >= NO_NODE) begin
							res_count_q <= '0; res_status_q <= ST_FULL;
							state_q <= S_DONE;
						end else begin
							state_q <= S_HEAD;
						end
					end
				end
				S_HEAD: state_q <= S_WALK;
				S_WALK: state_q <= cur_q[AW] ? S_DONE : S_NODE;
				S_NODE: state_q <= found ? S_DONE : S_WALK;
				S_DONE: begin
					if (!rsp.valid || rsp.ready) begin
						rsp.valid <= 1'b1;
						rsp.count <= res_count_q;
						rsp.status <= res_status_q;
						rsp.occupancy <= OCC_W'(stored_q);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= NO_NODE) else $error("node count exceeds pool size");
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_FULL |-> rsp.count == '0)
		else $error("refused insert with nonzero count");
	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		!(stored_inc && stored_dec)) else $error("node count inc and dec together");
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !req.ready) else $error("request taken during clear");

endmodule

@@ tb/sv/hck_tb_if.sv @@
// Testbench-side note: channel interfaces come from the RTL file hck_if.sv.
package hck_tb_pkg;
	timeunit 1ns;
	timeprecision 1ps;
	localparam int TB_ENTRIES = 1024;
	localparam int NO_NODE    = TB_ENTRIES;
	localparam logic [1:0] CMD_SPARE = 2'd3;
endpackage

@@ tb/sv/hck_counter_checker.sv @@
// Checker: predicts the key counter's responses and compares each transaction.
module hck_counter_checker import hck_pkg::*; import hck_tb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	hck_req_if   req,
	hck_rsp_if   rsp,
	output int   errors,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [COUNT_W-1:0]  count;
		logic [STATUS_W-1:0] status;
		logic [OCC_W-1:0]    occupancy;
	} rsp_t;

	int unsigned heads[TB_ENTRIES];
	logic [KEY_W-1:0] keys[TB_ENTRIES];
	logic [COUNT_W-1:0] counts[TB_ENTRIES];
	int unsigned links[TB_ENTRIES];
	int unsigned free_list[TB_ENTRIES];
	int unsigned used;
	rsp_t expected_rsps[$];

	initial begin
		errors = 0;
		for (int i = 0; i < TB_ENTRIES; i++) begin
			heads[i] = NO_NODE;
			links[i] = NO_NODE;
			free_list[i] = i;
		end
		used = 0;
	end

	function automatic int unsigned find_key(int unsigned b, logic [KEY_W-1:0] k,
			output int unsigned prior);
		int unsigned cur;
		cur = heads[b];
		prior = NO_NODE;
		while (cur < NO_NODE) begin
			if (keys[cur] == k) return cur;
			prior = cur;
			cur = links[cur];
		end
		prior = NO_NODE;
		return NO_NODE;
	endfunction

	function automatic rsp_t count_key(logic [CMD_W-1:0] op, logic [KEY_W-1:0] k);
		int unsigned b, n, prior;
		rsp_t r;
		b = k % TB_ENTRIES;
		r = '0;
		r.status = ST_OK;
		if (op == CMD_INSERT) begin
			if (used >= TB_ENTRIES) begin
				r.status = ST_FULL;
			end else begin
				n = find_key(b, k, prior);
				if (n < NO_NODE) begin
					if (counts[n] != COUNT_MAX) counts[n]++;
					r.count = counts[n];
				end else begin
					n = free_list[used];
					used++;
					keys[n] = k;
					counts[n] = 1;
					links[n] = heads[b];
					heads[b] = n;
					r.count = 1;
				end
			end
		end else if (op == CMD_REMOVE) begin
			n = find_key(b, k, prior);
			if (n >= NO_NODE) begin
				r.status = ST_NOT_FOUND;
			end else begin
				if (counts[n] != 0) counts[n]--;
				r.count = counts[n];
				if (counts[n] == 0) begin
					if (prior < NO_NODE) links[prior] = links[n];
					else heads[b] = links[n];
					links[n] = NO_NODE;
					used--;
					free_list[used] = n;
				end
			end
		end else begin
			n = find_key(b, k, prior);
			if (n >= NO_NODE) r.status = ST_NOT_FOUND;
			else r.count = counts[n];
		end
		r.occupancy = used[OCC_W-1:0];
		return r;
	endfunction

	assign pending = expected_rsps.size();

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (req.valid && req.ready)
				expected_rsps.push_back(count_key(req.cmd, req.key));
			if (rsp.valid && rsp.ready) begin
				if (expected_rsps.size() == 0) begin
					$error("response with no request outstanding");
					errors++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, rsp.count);
						errors++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						errors++;
					end
					if (rsp.occupancy !== want.occupancy) begin
						$error("occupancy: expected %0d, got %0d", want.occupancy,
							rsp.occupancy);
						errors++;
					end
				end
			end
		end
	end
endmodule

@@ tb/sv/chained_hash_key_counter_unit_test.sv @@
// Top: drives request stimulus, random response stalls, and gives the verdict.
module chained_hash_key_counter_unit_test import hck_pkg::*; import hck_tb_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int errors, pending;
	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_off = 1'b0;
	logic [KEY_W-1:0] pool[$];

	hck_req_if req();
	hck_rsp_if rsp();

	chained_hash_key_counter_unit DUT (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));
	hck_counter_checker checker_i (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.errors(errors), .pending(pending));

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		req.valid = 1'b0;
		req.cmd = CMD_INSERT;
		req.key = '0;
		rsp.ready = 1'b0;
	end

	always @(posedge clk) begin
		if (hold_off) rsp.ready <= 1'b0;
		else rsp.ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send(logic [CMD_W-1:0] op, logic [KEY_W-1:0] k);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= op;
		req.key <= k;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		if (pool.size() != 0 && $urandom_range(3) != 0)
			return pool[$urandom_range(pool.size() - 1)];
		return $urandom();
	endfunction

	task automatic random_phase(int n);
		logic [KEY_W-1:0] k;
		int r;
		for (int i = 0; i < n; i++) begin
			k = pick_key();
			r = $urandom_range(9);
			if (r < 5) begin
				send(CMD_INSERT, k);
				if (pool.size() < 48) pool.push_back(k);
			end else if (r < 8) send(CMD_REMOVE, k);
			else send(r == 8 ? CMD_LOOKUP : CMD_SPARE, k);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, chains in one bucket, head removal, unused code
		send(CMD_LOOKUP, 32'h0);
		send(CMD_REMOVE, 32'hFFFF_FFFF);
		send(CMD_INSERT, 32'h0);
		send(CMD_INSERT, 32'hFFFF_FFFF);
		send(CMD_INSERT, 32'h0000_0400);
		send(CMD_INSERT, 32'h0000_0800);
		send(CMD_INSERT, 32'h0000_0400);
		send(CMD_SPARE, 32'h0000_0400);
		send(CMD_REMOVE, 32'h0000_0800);
		send(CMD_LOOKUP, 32'h0000_0400);
		send(CMD_LOOKUP, 32'h0);
		send(CMD_REMOVE, 32'h0);
		send(CMD_REMOVE, 32'h0);
		send(CMD_INSERT, 32'hAAAA_AAAA);
		send(CMD_INSERT, 32'h5555_5555);
		send(CMD_REMOVE, 32'h0000_0400);
		send(CMD_REMOVE, 32'h0000_0400);
		send(CMD_LOOKUP, 32'hFFFF_FFFF);
		drain();
		random_phase(150);
		send_idle_pct = 72;
		random_phase(100);
		send_idle_pct = 0;
		stall_pct = 72;
		random_phase(100);
		send_idle_pct = 20;
		stall_pct = 20;
		random_phase(100);
		drain();
		send_idle_pct = 0;
		stall_pct = 0;
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				random_phase(60);
				req.valid <= 1'b0;
				@(posedge clk);
			end
		join
		drain();
		// burst of fresh keys
		for (int i = 0; i < 80; i++) send(CMD_INSERT, $urandom());
		send(CMD_INSERT, pool.size() ? pool[0] : 32'h0);
		send(CMD_LOOKUP, 32'h1234_5678);
		send(CMD_REMOVE, $urandom());
		random_phase(40);
		drain();
		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end
endmodule

@@ files.f @@
rtl/hck_pkg.sv
rtl/hck_if.sv
rtl/chained_hash_key_counter_unit.sv
tb/sv/hck_tb_if.sv
tb/sv/hck_counter_checker.sv
tb/sv/chained_hash_key_counter_unit_test.sv
